// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR    = 3'd0,
    CMD_SET_CURSOR  = 3'd1,
    CMD_WRITE_CELL  = 3'd2,
    CMD_READ_CELL   = 3'd3,
    CMD_CLEAR       = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_RDATA,
    S_EMIT
  } state_t;

  // where to go once a store sweep has finished
  typedef enum logic [1:0] {
    AFTER_IDLE,
    AFTER_EXEC,
    AFTER_EMIT
  } after_t;

  localparam logic       REG_SCREEN_WIDTH  = 1'b0;
  localparam logic       REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] RESET_WIDTH  = 8'd80;
  localparam logic [5:0] RESET_HEIGHT = 6'd25;

  localparam logic [15:0] BLANK_CELL   = 16'h0020;
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;

endpackage

// ----- rtl/tcw_store.sv -----
module tcw_store #(
  parameter int DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sweep_start,
  input  logic [$clog2(DEPTH+1)-1:0]   sweep_step,
  input  logic [$clog2(DEPTH+1)-1:0]   sweep_keep,
  input  logic [$clog2(DEPTH+1)-1:0]   sweep_total,
  output logic                         sweep_busy,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [15:0]                  wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [15:0]                  rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_q;

  logic [CW-1:0] cnt;
  logic [CW-1:0] step;
  logic [CW-1:0] keep;
  logic [CW-1:0] total;
  logic          pend;
  logic          pend_blank;
  logic [AW-1:0] pend_addr;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_wdata;

  // Sweep: cell i takes cell i+step while i < keep, blank up to total.
  // The read for cell i is issued in the cycle before its write.
  always_comb begin
    if (sweep_busy) begin
      mem_we    = pend;
      mem_waddr = pend_addr;
      mem_wdata = pend_blank ? tcw_pkg::BLANK_CELL : rd_q;
      mem_re    = (cnt < keep);
      mem_raddr = AW'(cnt + step);
    end else begin
      mem_we    = we;
      mem_waddr = waddr;
      mem_wdata = wdata;
      mem_re    = re;
      mem_raddr = raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign rdata = rd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_busy <= 1'b1;
      cnt        <= '0;
      step       <= '0;
      keep       <= '0;
      total      <= CW'(DEPTH);
      pend       <= 1'b0;
    end else if (sweep_start) begin
      sweep_busy <= 1'b1;
      cnt        <= '0;
      step       <= sweep_step;
      keep       <= sweep_keep;
      total      <= sweep_total;
      pend       <= 1'b0;
    end else if (sweep_busy) begin
      if (cnt < total) begin
        pend <= 1'b1;
        cnt  <= cnt + 1'b1;
      end else begin
        pend       <= 1'b0;
        sweep_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr  <= AW'(cnt);
    pend_blank <= (cnt >= keep);
  end

endmodule

// ----- rtl/text_console_writer.sv -----
// Text-mode console writer: a screen of character/color cells at
// address row * width + column, held in one single-port-write memory.
// Input items arrive on s_axis (command, character, color, column, row);
// each item gives exactly one result on m_axis (cursor column and row,
// read character and color, bad position flag). Screen width and height
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// An item is accepted in the idle state; its result is loaded into the output
// register from S_EXEC, or from S_RDATA after a read (the memory read is
// registered), or from S_EMIT after a clear or a scroll on a newline.
// A scroll copies the visible area through the memory one cell per cycle;
// a wrap followed by a newline on the bottom row scrolls twice. Clear blanks
// the whole store. These sweeps hold s_axis_tready low. Reset starts the
// same blanking pass and homes the cursor; no item is taken until it ends.
// When m_axis is stalled the result stays in the output register and the
// next item may be accepted, but it is not finished until the register
// frees up.
module text_console_writer #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], ch[10:3], color[18:11], col[26:19], row[31:27]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_col[7:0], cursor_row[12:8], read_char[20:13], read_color[28:21],
  // bad_position[29], zero[31:30]
  output logic [31:0] m_axis_tdata
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_COLUMNS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int YW    = $clog2(MAX_ROWS);

  tcw_pkg::state_t state, state_next;
  tcw_pkg::after_t after, after_next;

  logic [7:0]    width_cfg;
  logic [5:0]    height_cfg;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [WW-1:0] cursor_x, x_next;
  logic [YW-1:0] cursor_y, y_next;

  logic [2:0]    it_cmd;
  logic [7:0]    it_ch;
  logic [7:0]    it_color;
  logic [7:0]    it_col;
  logic [4:0]    it_row;

  logic          out_valid;
  logic [7:0]    out_col;
  logic [4:0]    out_row;
  logic [7:0]    out_char;
  logic [7:0]    out_color;
  logic          out_bad;
  logic          out_free;

  logic          emit;
  logic [7:0]    res_char;
  logic [7:0]    res_color;
  logic          res_bad;

  logic          wrap;
  logic [WW-1:0] x1;
  logic [YW:0]   y1;
  logic [YW:0]   y2;
  logic [YW-1:0] h_last;
  logic          in_range;
  logic [AW-1:0] rowsel;
  logic [AW-1:0] colsel;
  logic [AW-1:0] addr;
  logic [CW-1:0] total_hw;

  logic          sweep_start;
  logic          sweep_busy;
  logic [CW-1:0] sweep_keep;
  logic [CW-1:0] sweep_total;
  logic          st_we;
  logic          st_re;
  logic [15:0]   st_rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= tcw_pkg::RESET_WIDTH;
      height_cfg <= tcw_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_SCREEN_WIDTH:  width_cfg  <= cfg_data;
        tcw_pkg::REG_SCREEN_HEIGHT: height_cfg <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg == 8'd0) begin
      w_eff = WW'(1);
    end else if (int'(width_cfg) > MAX_COLUMNS) begin
      w_eff = WW'(MAX_COLUMNS);
    end else begin
      w_eff = WW'(width_cfg);
    end
    if (height_cfg == 6'd0) begin
      h_eff = HW'(1);
    end else if (int'(height_cfg) > MAX_ROWS) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(height_cfg);
    end
  end

  // item capture
  assign s_axis_tready = (state == tcw_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      it_cmd   <= s_axis_tdata[2:0];
      it_ch    <= s_axis_tdata[10:3];
      it_color <= s_axis_tdata[18:11];
      it_col   <= s_axis_tdata[26:19];
      it_row   <= s_axis_tdata[31:27];
    end
  end

  // cursor arithmetic; rerunning the wrap step after a scroll changes nothing
  assign wrap     = (cursor_x >= w_eff);
  assign x1       = wrap ? '0 : cursor_x;
  assign y1       = (YW+1)'(cursor_y) + (YW+1)'(wrap);
  assign y2       = y1 + 1'b1;
  assign h_last   = YW'(h_eff - 1'b1);
  assign in_range = (WW'(it_col) < w_eff) && (int'(it_col) < MAX_COLUMNS + 1)
                    && (HW'(it_row) < h_eff) && (int'(it_row) < MAX_ROWS + 1);
  assign rowsel   = (it_cmd == tcw_pkg::CMD_PUT_CHAR) ? AW'(y1) : AW'(it_row);
  assign colsel   = (it_cmd == tcw_pkg::CMD_PUT_CHAR) ? AW'(x1) : AW'(it_col);
  assign addr     = rowsel * AW'(w_eff) + colsel;
  assign total_hw = CW'(h_eff) * CW'(w_eff);

  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next  = state;
    after_next  = after;
    x_next      = cursor_x;
    y_next      = cursor_y;
    emit        = 1'b0;
    res_char    = '0;
    res_color   = '0;
    res_bad     = 1'b0;
    sweep_start = 1'b0;
    sweep_keep  = total_hw - CW'(w_eff);
    sweep_total = total_hw;
    st_we       = 1'b0;
    st_re       = 1'b0;
    unique case (state)
      tcw_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = tcw_pkg::S_EXEC;
        end
      end
      tcw_pkg::S_EXEC: begin
        if (out_free) begin
          unique case (it_cmd)
            tcw_pkg::CMD_PUT_CHAR: begin
              if (y1 >= (YW+1)'(h_eff)) begin
                x_next      = x1;
                y_next      = h_last;
                sweep_start = 1'b1;
                after_next  = tcw_pkg::AFTER_EXEC;
                state_next  = tcw_pkg::S_SWEEP;
              end else if (it_ch == tcw_pkg::NEWLINE_CODE) begin
                x_next = '0;
                if (y2 >= (YW+1)'(h_eff)) begin
                  y_next      = h_last;
                  sweep_start = 1'b1;
                  after_next  = tcw_pkg::AFTER_EMIT;
                  state_next  = tcw_pkg::S_SWEEP;
                end else begin
                  y_next     = YW'(y2);
                  emit       = 1'b1;
                  state_next = tcw_pkg::S_IDLE;
                end
              end else begin
                st_we      = 1'b1;
                x_next     = x1 + 1'b1;
                y_next     = YW'(y1);
                emit       = 1'b1;
                state_next = tcw_pkg::S_IDLE;
              end
            end
            tcw_pkg::CMD_SET_CURSOR: begin
              if (in_range) begin
                x_next = WW'(it_col);
                y_next = YW'(it_row);
              end else begin
                res_bad = 1'b1;
              end
              emit       = 1'b1;
              state_next = tcw_pkg::S_IDLE;
            end
            tcw_pkg::CMD_WRITE_CELL: begin
              if (in_range) begin
                st_we = 1'b1;
              end else begin
                res_bad = 1'b1;
              end
              emit       = 1'b1;
              state_next = tcw_pkg::S_IDLE;
            end
            tcw_pkg::CMD_READ_CELL: begin
              if (in_range) begin
                st_re      = 1'b1;
                state_next = tcw_pkg::S_RDATA;
              end else begin
                res_bad    = 1'b1;
                emit       = 1'b1;
                state_next = tcw_pkg::S_IDLE;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              x_next      = '0;
              y_next      = '0;
              sweep_start = 1'b1;
              sweep_keep  = '0;
              sweep_total = CW'(DEPTH);
              after_next  = tcw_pkg::AFTER_EMIT;
              state_next  = tcw_pkg::S_SWEEP;
            end
            default: begin
              emit       = 1'b1;
              state_next = tcw_pkg::S_IDLE;
            end
          endcase
        end
      end
      tcw_pkg::S_SWEEP: begin
        if (!sweep_busy) begin
          unique case (after)
            tcw_pkg::AFTER_EXEC: state_next = tcw_pkg::S_EXEC;
            tcw_pkg::AFTER_EMIT: state_next = tcw_pkg::S_EMIT;
            default:             state_next = tcw_pkg::S_IDLE;
          endcase
        end
      end
      tcw_pkg::S_RDATA: begin
        if (out_free) begin
          res_char   = st_rdata[7:0];
          res_color  = st_rdata[15:8];
          emit       = 1'b1;
          state_next = tcw_pkg::S_IDLE;
        end
      end
      tcw_pkg::S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = tcw_pkg::S_IDLE;
        end
      end
      default: state_next = tcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::S_SWEEP;
      after    <= tcw_pkg::AFTER_IDLE;
      cursor_x <= '0;
      cursor_y <= '0;
    end else begin
      state    <= state_next;
      after    <= after_next;
      cursor_x <= x_next;
      cursor_y <= y_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_col   <= 8'(x_next);
      out_row   <= 5'(y_next);
      out_char  <= res_char;
      out_color <= res_color;
      out_bad   <= res_bad;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_bad, out_color, out_char, out_row, out_col};

  tcw_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .sweep_start (sweep_start),
    .sweep_step  (CW'(w_eff)),
    .sweep_keep  (sweep_keep),
    .sweep_total (sweep_total),
    .sweep_busy  (sweep_busy),
    .we          (st_we),
    .waddr       (addr),
    .wdata       ({it_color, it_ch}),
    .re          (st_re),
    .raddr       (addr),
    .rdata       (st_rdata)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !sweep_busy)
    else $error("item accepted while the store sweep runs");

  a_sweep_starts: assert property (@(posedge clk) disable iff (rst)
    sweep_start |=> sweep_busy)
    else $error("sweep request not taken by the store");

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (st_we || st_re) |-> !sweep_busy)
    else $error("cell access collides with a store sweep");

  a_put_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (emit && state == tcw_pkg::S_EXEC && it_cmd == tcw_pkg::CMD_PUT_CHAR)
      |-> ((YW+1)'(y_next) < (YW+1)'(h_eff)))
    else $error("put char left the cursor below the screen");

endmodule
